// File: sv/ftc_pkg.sv
package ftc_pkg;
    localparam int COUNT_BITS = 40;
    localparam int MAG_BITS   = COUNT_BITS - 1;
    localparam int HOUR_BITS  = 28;
    localparam int MIN_BITS   = 6;
    localparam int SEC_BITS   = 6;
    localparam int FRM_BITS   = 8;
    localparam int RATE_BITS  = 8;
    localparam int IDX_BITS   = 1;

    typedef enum logic [IDX_BITS-1:0] {
        REG_FRAME_RATE = 1'd0,
        REG_DROP_EN    = 1'd1
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_DF30  = 2'd1,
        MODE_DF60  = 2'd2
    } t_mode;
endpackage

// File: sv/frame_count_to_timecode_core.sv
// Throughput: one word per cycle; a stalled output holds the whole pipeline.
// The quotient bits are produced by a chain of restoring-division stages, one
// quotient bit per stage, followed by two small-divisor chains of five bits per stage.
// Reset (synchronous, active low): frame_rate 30, drop-frame off, pipeline empty.
module frame_count_to_timecode_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ftc_pkg::IDX_BITS-1:0]        i_cfg_idx,
    input  logic [ftc_pkg::RATE_BITS-1:0]       i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [ftc_pkg::COUNT_BITS-1:0] i_frame_count,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [ftc_pkg::HOUR_BITS-1:0]       o_hours,
    output logic [ftc_pkg::MIN_BITS-1:0]        o_minutes,
    output logic [ftc_pkg::SEC_BITS-1:0]        o_seconds,
    output logic [ftc_pkg::FRM_BITS-1:0]        o_frame_in_second,
    output logic                                o_drop_used
);
    import ftc_pkg::*;

    localparam int DW  = 17; // divisor width (max 35964)
    localparam int QW  = MAG_BITS;
    localparam int NS  = MAG_BITS + 1;      // stage 0 entry, stages 1..MAG_BITS
    localparam int XW  = QW + 4;
    localparam int SPS = 5;
    localparam int XS  = (XW + SPS - 1) / SPS;
    localparam int PS  = 2 * XS + 1;

    logic [RATE_BITS-1:0] r_rate;
    logic                 r_drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_BITS'(30);
            r_drop <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_FRAME_RATE: r_rate <= i_cfg_data;
                REG_DROP_EN:    r_drop <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic adv;
    assign adv = !o_valid || i_ready;
    assign o_ready = adv;

    function automatic logic [XW+5:0] split_step(logic [XW-1:0] q_in, logic [5:0] r_in,
                                                 logic [5:0] d, int base);
        logic [XW-1:0] q;
        logic [5:0]    r;
        logic [6:0]    t;
        q = q_in;
        r = r_in;
        for (int j = 0; j < SPS; j++) begin
            if (base + j < XW) begin
                t = {r, q[XW-1]};
                if (t >= {1'b0, d}) begin
                    r = 6'(t - {1'b0, d});
                    q = {q[XW-2:0], 1'b1};
                end else begin
                    r = t[5:0];
                    q = {q[XW-2:0], 1'b0};
                end
            end
        end
        return {q, r};
    endfunction

    // Division stage array: dividend n / d, d = block (drop) or rate.
    logic [NS-1:0]         r_v;
    logic [QW-1:0]         r_q   [NS];
    logic [DW-1:0]         r_rem [NS];
    logic [DW-1:0]         r_d   [NS];
    t_mode                 r_mode[NS];

    logic [RATE_BITS-1:0] eff_rate;
    t_mode mode_in;
    assign eff_rate = (r_rate == '0) ? RATE_BITS'(30) : r_rate;
    always_comb begin
        mode_in = MODE_PLAIN;
        if (r_drop && eff_rate == RATE_BITS'(30)) mode_in = MODE_DF30;
        else if (r_drop && eff_rate == RATE_BITS'(60)) mode_in = MODE_DF60;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (adv) r_v <= {r_v[NS-2:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_q[0]    <= i_frame_count[COUNT_BITS-1] ? '0 : i_frame_count[QW-1:0];
            r_rem[0]  <= '0;
            r_mode[0] <= mode_in;
            case (mode_in)
                MODE_DF30: r_d[0] <= DW'(17982);
                MODE_DF60: r_d[0] <= DW'(35964);
                default:   r_d[0] <= DW'(eff_rate);
            endcase
            for (int k = 1; k < NS; k++) begin
                logic [DW:0] t;
                t = {r_rem[k-1], r_q[k-1][QW-1]};
                r_mode[k] <= r_mode[k-1];
                r_d[k]    <= r_d[k-1];
                if (t >= {1'b0, r_d[k-1]}) begin
                    r_rem[k] <= DW'(t - {1'b0, r_d[k-1]});
                    r_q[k]   <= {r_q[k-1][QW-2:0], 1'b1};
                end else begin
                    r_rem[k] <= t[DW-1:0];
                    r_q[k]   <= {r_q[k-1][QW-2:0], 1'b0};
                end
            end
        end
    end

    // Post stages: quotient Q (tens or secs), remainder R.
    logic [QW-1:0]  qn;
    logic [DW-1:0]  rn;
    t_mode          mn;
    assign qn = r_q[NS-1];
    assign rn = r_rem[NS-1];
    assign mn = r_mode[NS-1];

    // P1: drop: compute ones & frame-within-minute; plain: secs = Q, f = R
    logic [PS-1:0]    r_pv;
    logic [XW-1:0]    p1_mins;  // minutes (drop) or secs (plain)
    logic [DW-1:0]    p1_rem;   // frame in minute (drop) / frame (plain)
    t_mode            p1_mode;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            logic [DW-1:0] first, later, skip, past;
            logic [3:0] ones;
            logic [DW-1:0] rr;
            first = (mn == MODE_DF60) ? DW'(3600) : DW'(1800);
            later = (mn == MODE_DF60) ? DW'(3596) : DW'(1798);
            skip  = (mn == MODE_DF60) ? DW'(4) : DW'(2);
            past = rn - first;
            ones = '0;
            rr = rn;
            if (mn != MODE_PLAIN && rn >= first) begin
                // past < 9*later; find ones by comparisons
                ones = 4'd1;
                for (int j = 1; j < 9; j++)
                    if (past >= DW'(j) * later) ones = 4'(j + 1);
                rr = past - DW'(ones - 4'd1) * later + skip;
            end
            p1_mode <= mn;
            p1_rem  <= rr;
            if (mn != MODE_PLAIN) p1_mins <= XW'(qn) * XW'(10) + XW'(ones);
            else                  p1_mins <= XW'(qn);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pv <= '0;
        else if (adv) r_pv <= {r_pv[PS-2:0], r_v[NS-1]};
    end

    // Chain A: split X into X/60 and X%60.
    logic [XW-1:0]  r_aq  [XS];
    logic [5:0]     r_ar  [XS];
    logic [DW-1:0]  r_afr [XS];
    t_mode          r_amd [XS];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            {r_aq[0], r_ar[0]} <= split_step(p1_mins, '0, 6'd60, 0);
            r_afr[0] <= p1_rem;
            r_amd[0] <= p1_mode;
            for (int k = 1; k < XS; k++) begin
                {r_aq[k], r_ar[k]} <= split_step(r_aq[k-1], r_ar[k-1], 6'd60, k * SPS);
                r_afr[k] <= r_afr[k-1];
                r_amd[k] <= r_amd[k-1];
            end
        end
    end

    // Chain B: drop: frame in minute by nominal rate; plain: minutes by 60.
    logic [XW-1:0]        r_bq  [XS];
    logic [5:0]           r_br  [XS];
    logic [HOUR_BITS-1:0] r_bh  [XS];
    logic [5:0]           r_bm  [XS];
    logic [FRM_BITS-1:0]  r_bf  [XS];
    t_mode                r_bmd [XS];

    t_mode         a_md;
    logic [XW-1:0] b_in;
    logic [5:0]    b_div;
    assign a_md  = r_amd[XS-1];
    assign b_in  = (a_md == MODE_PLAIN) ? r_aq[XS-1] : XW'(r_afr[XS-1]);
    assign b_div = (a_md == MODE_DF30) ? 6'd30 : 6'd60;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            {r_bq[0], r_br[0]} <= split_step(b_in, '0, b_div, 0);
            r_bh[0]  <= HOUR_BITS'(r_aq[XS-1]);
            r_bm[0]  <= r_ar[XS-1];
            r_bf[0]  <= FRM_BITS'(r_afr[XS-1]);
            r_bmd[0] <= a_md;
            for (int k = 1; k < XS; k++) begin
                {r_bq[k], r_br[k]} <= split_step(r_bq[k-1], r_br[k-1],
                    (r_bmd[k-1] == MODE_DF30) ? 6'd30 : 6'd60, k * SPS);
                r_bh[k]  <= r_bh[k-1];
                r_bm[k]  <= r_bm[k-1];
                r_bf[k]  <= r_bf[k-1];
                r_bmd[k] <= r_bmd[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_bmd[XS-1] != MODE_PLAIN) begin
                o_hours           <= r_bh[XS-1];
                o_minutes         <= r_bm[XS-1];
                o_seconds         <= SEC_BITS'(r_bq[XS-1]);
                o_frame_in_second <= FRM_BITS'(r_br[XS-1]);
                o_drop_used       <= 1'b1;
            end else begin
                o_hours           <= HOUR_BITS'(r_bq[XS-1]);
                o_minutes         <= r_br[XS-1];
                o_seconds         <= r_bm[XS-1];
                o_frame_in_second <= r_bf[XS-1];
                o_drop_used       <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (adv) o_valid <= r_pv[PS-1];
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hours))
        else $error("output lost under stall");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_drop_used |-> o_frame_in_second < FRM_BITS'(60))
        else $error("drop frame out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_minutes < MIN_BITS'(60) && o_seconds < SEC_BITS'(60))
        else $error("minutes/seconds out of range");
endmodule
